FILE: rtl/touch_adc_serial_bit_exchange_unit_assert.svh
// Assertion macros for the serial touch ADC exchange unit.
// Included by the top level; expects clk and rst in scope.
`ifndef TOUCH_ADC_SERIAL_BIT_EXCHANGE_UNIT_ASSERT_SVH
`define TOUCH_ADC_SERIAL_BIT_EXCHANGE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TASBX_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define TASBX_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/tasbx_pkg.sv
// Types and constants for the serial touch ADC exchange unit.
// No dependencies; used by every module of the block.
package tasbx_pkg;

  typedef struct packed {
    logic        func;
    logic        bit_in;
    logic        cs_level;
    logic        touched;
    logic [12:0] touch_x;
    logic [12:0] touch_y;
    logic [2:0]  dock_port;
  } in_item_t;

  typedef struct packed {
    logic data_out;
    logic pen_irq_enabled;
  } out_item_t;

  typedef struct packed {
    logic [2:0] channel;
    logic       eight;
    logic       single;
    logic [1:0] pd;
  } conv_ctrl_t;

  localparam logic FUNC_BIT = 1'b0;
  localparam logic FUNC_CS  = 1'b1;

  localparam logic [2:0] CH_TEMP0 = 3'd0;
  localparam logic [2:0] CH_Y     = 3'd1;
  localparam logic [2:0] CH_VBAT  = 3'd2;
  localparam logic [2:0] CH_Z1    = 3'd3;
  localparam logic [2:0] CH_Z2    = 3'd4;
  localparam logic [2:0] CH_X     = 3'd5;
  localparam logic [2:0] CH_AUX   = 3'd6;
  localparam logic [2:0] CH_TEMP1 = 3'd7;

  localparam logic [1:0] PD_REF_ONLY = 2'd2;

  localparam logic [3:0] BITS_START   = 4'd15;
  localparam logic [3:0] BITS_CTRL    = 4'd8;
  localparam logic [3:0] BITS_CONVERT = 4'd6;
  localparam logic [3:0] BITS_SHORT   = 4'd4;

  localparam logic [7:0]  CTRL_START  = 8'h01;
  localparam logic [15:0] RESULT_MSB8 = 16'hFF00;

  localparam logic [11:0] READ_MAX     = 12'hFFF;
  localparam logic [11:0] READ_ZERO    = 12'h000;
  localparam logic [11:0] READ_SINGLE_T = 12'hF80;

  localparam logic [11:0] Y_LO  = 12'h0EE;
  localparam logic [11:0] Y_HI  = 12'hEE4;
  localparam logic [11:0] Z1_LO = 12'h093;
  localparam logic [11:0] Z1_HI = 12'h600;
  localparam logic [11:0] Z1_SPAN2 = 12'h280;
  localparam logic [11:0] Z2_LO = 12'h9AF;
  localparam logic [11:0] Z2_HI = 12'hF3F;
  localparam logic [11:0] Z2_SPAN2 = 12'h150;
  localparam logic [11:0] X_LO  = 12'h0FD;
  localparam logic [11:0] X_HI  = 12'hF47;

  function automatic logic [11:0] dock_reading(input logic [2:0] dock);
    logic [11:0] r;
    case (dock)
      3'd0:    r = 12'hFFF;
      3'd1:    r = 12'h1EB;
      default: r = 12'h000;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] single_reading(input logic [2:0] ch, input logic [2:0] dock);
    logic [11:0] r;
    case (ch)
      CH_TEMP0: r = 12'h3E2;
      CH_Y:     r = 12'hFFF;
      CH_VBAT:  r = 12'h69C;
      CH_Z1:    r = 12'h000;
      CH_Z2:    r = 12'hFFF;
      CH_X:     r = 12'h3FB;
      CH_AUX:   r = dock_reading(dock);
      default:  r = 12'h4A1;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] diff_idle_reading(input logic [2:0] ch);
    logic [11:0] r;
    case (ch)
      CH_Y:     r = 12'hFEF;
      CH_Z1:    r = 12'h000;
      CH_Z2:    r = 12'hFFF;
      CH_X:     r = 12'h309;
      CH_TEMP1: r = 12'hDFF;
      default:  r = 12'hFFF;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tasbx_reading.sv
// Conversion value for one control byte and the current touch inputs.
// Depends on tasbx_pkg; used by tasbx_core.
module tasbx_reading import tasbx_pkg::*; #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  conv_ctrl_t  ctrl,
  input  logic        touched,
  input  logic [12:0] touch_x,
  input  logic [12:0] touch_y,
  input  logic [2:0]  dock_port,
  output logic [11:0] value
);

  localparam int CW    = (COORD_FRAC_BITS + 1 > 13) ? COORD_FRAC_BITS + 1 : 13;
  localparam int PW    = CW + 12;
  localparam int ACC_W = PW + 1;
  localparam logic [CW-1:0] ONE = CW'(1 << COORD_FRAC_BITS);

  localparam logic [11:0] Y_SPAN  = Y_HI - Y_LO;
  localparam logic [11:0] Z1_SPAN = Z1_HI - Z1_LO;
  localparam logic [11:0] Z2_SPAN = Z2_HI - Z2_LO;
  localparam logic [11:0] X_SPAN  = X_HI - X_LO;

  logic [CW-1:0]    x_ext, y_ext, x_cl, y_cl, inv_x, inv_y;
  logic [CW-1:0]    inv1, inv2;
  logic [11:0]      lo, span1, span2;
  logic [ACC_W-1:0] acc, quo;
  logic [ACC_W:0]   sum;
  logic [11:0]      mapped;

  always_comb begin
    x_ext = CW'(touch_x);
    y_ext = CW'(touch_y);
    x_cl  = (x_ext > ONE) ? ONE : x_ext;
    y_cl  = (y_ext > ONE) ? ONE : y_ext;
    inv_x = ONE - x_cl;
    inv_y = ONE - y_cl;
  end

  always_comb begin
    inv1  = '0;
    inv2  = '0;
    lo    = '0;
    span1 = '0;
    span2 = '0;
    case (ctrl.channel)
      CH_Y: begin
        inv1  = inv_y;
        lo    = Y_LO;
        span1 = Y_SPAN;
      end
      CH_Z1: begin
        inv1  = inv_x;
        lo    = Z1_LO;
        span1 = Z1_SPAN;
        inv2  = inv_y;
        span2 = Z1_SPAN2;
      end
      CH_Z2: begin
        inv1  = inv_y;
        lo    = Z2_LO;
        span1 = Z2_SPAN;
        inv2  = inv_x;
        span2 = Z2_SPAN2;
      end
      CH_X: begin
        inv1  = inv_x;
        lo    = X_LO;
        span1 = X_SPAN;
      end
      default: begin
        inv1 = '0;
      end
    endcase
  end

  always_comb begin
    acc    = ACC_W'(PW'(inv1) * PW'(span1)) + ACC_W'(PW'(inv2) * PW'(span2));
    quo    = acc >> COORD_FRAC_BITS;
    sum    = (ACC_W + 1)'(lo) + (ACC_W + 1)'(quo);
    mapped = (sum > (ACC_W + 1)'(READ_MAX)) ? READ_MAX : sum[11:0];
  end

  always_comb begin
    if (ctrl.pd == PD_REF_ONLY) begin
      value = ((ctrl.channel == CH_Z1 || ctrl.channel == CH_X) && !touched) ?
              READ_ZERO : READ_MAX;
    end else if (!ctrl.single) begin
      if (touched && (ctrl.channel == CH_Y || ctrl.channel == CH_Z1 ||
                      ctrl.channel == CH_Z2 || ctrl.channel == CH_X)) begin
        value = mapped;
      end else begin
        value = diff_idle_reading(ctrl.channel);
      end
    end else if (touched) begin
      value = READ_SINGLE_T;
    end else begin
      value = single_reading(ctrl.channel, dock_port);
    end
  end

endmodule

FILE: rtl/tasbx_core.sv
// Serial exchange state: bit counter, control and result shift registers.
// Depends on tasbx_pkg and tasbx_reading.
module tasbx_core import tasbx_pkg::*; #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [3:0]  bits_left, bits_left_next;
  logic [7:0]  control_shift, control_shift_next;
  logic [15:0] result_shift, result_shift_next;
  logic        deselected, deselected_next;
  logic        irq_enable, irq_enable_next;
  logic        dout;
  conv_ctrl_t  ctrl;
  logic [11:0] value;

  assign ctrl = '{channel: control_shift[6:4], eight: control_shift[3],
                  single: control_shift[2], pd: control_shift[1:0]};

  tasbx_reading #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_reading (
    .ctrl     (ctrl),
    .touched  (item.touched),
    .touch_x  (item.touch_x),
    .touch_y  (item.touch_y),
    .dock_port(item.dock_port),
    .value    (value)
  );

  always_comb begin
    bits_left_next     = bits_left;
    control_shift_next = control_shift;
    result_shift_next  = result_shift;
    deselected_next    = deselected;
    irq_enable_next    = irq_enable;
    dout               = 1'b1;
    if (item.func == FUNC_CS) begin
      if (item.cs_level && !deselected) begin
        bits_left_next     = '0;
        control_shift_next = '0;
        result_shift_next  = '0;
        irq_enable_next    = 1'b1;
      end
      deselected_next = item.cs_level;
      dout            = item.cs_level;
    end else if (!deselected) begin
      if (bits_left_next != 4'd0) begin
        bits_left_next = bits_left_next - 4'd1;
      end
      if (bits_left_next == 4'd0) begin
        if (item.bit_in) begin
          control_shift_next = CTRL_START;
          bits_left_next     = BITS_START;
        end
      end else if (bits_left_next >= BITS_CTRL) begin
        control_shift_next = {control_shift[6:0], item.bit_in};
      end else if (bits_left_next == BITS_CONVERT) begin
        result_shift_next = {value, 4'b0000};
        if (ctrl.eight) begin
          result_shift_next = result_shift_next & RESULT_MSB8;
          bits_left_next    = bits_left_next - BITS_SHORT;
        end
        irq_enable_next = !ctrl.pd[0];
      end
      dout              = result_shift_next[15];
      result_shift_next = {result_shift_next[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left     <= '0;
      control_shift <= '0;
      result_shift  <= '0;
      deselected    <= 1'b1;
      irq_enable    <= 1'b1;
    end else if (fire) begin
      bits_left     <= bits_left_next;
      control_shift <= control_shift_next;
      result_shift  <= result_shift_next;
      deselected    <= deselected_next;
      irq_enable    <= irq_enable_next;
    end
  end

  assign result = '{data_out: dout, pen_irq_enabled: irq_enable_next};

endmodule

FILE: rtl/touch_adc_serial_bit_exchange_unit.sv
// Serial touch ADC exchange unit, top level.
// Channels: req carries one item per serial clock bit or chip-select change;
// rsp returns one item per request with the data-out bit and the pen
// interrupt enable. Both use valid/stall; an item moves when valid is high
// and stall is low.
// Path: a request goes into the input register, then through the exchange
// logic into the response register.
// Throughput: one item per cycle while rsp is not stalled; the exchange
// state loop updates once per accepted item.
// Stall: while rsp is stalled the response register holds; one more request
// is taken into the input register, after which req_stall rises.
// Reset (rst, synchronous): drops all queued items, deselects the chip and
// sets the pen interrupt enable.
// Depends on tasbx_pkg, tasbx_core and the assertion macro header.
`include "touch_adc_serial_bit_exchange_unit_assert.svh"

module touch_adc_serial_bit_exchange_unit import tasbx_pkg::*; #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  logic      fire;
  out_item_t core_result;

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && advance;
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_item <= req;
    end
  end

  tasbx_core #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (s1_item),
    .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= core_result;
    end
  end

  `TASBX_ASSERT_ALWAYS(a_stall_needs_item, !req_stall || s1_valid, "stall with empty input register")
  `TASBX_ASSERT_NEXT(a_hold_when_blocked, s1_valid && !advance, s1_valid, "input item lost while blocked")
  `TASBX_ASSERT_NEXT(a_deselect_result, fire && s1_item.func == FUNC_CS && s1_item.cs_level,
    rsp_valid && rsp.data_out && rsp.pen_irq_enabled, "deselect must drive data out and irq enable high")

endmodule
